@@ rtl/core/sorted_schedule_table_defines.svh @@
// Assertion macros shared by the schedule table RTL.
// Each macro expands to one labelled concurrent assertion on clk,
// switched off while arst_n is low.
`ifndef SORTED_SCHEDULE_TABLE_DEFINES_SVH
`define SORTED_SCHEDULE_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/sst_pkg.sv @@
package sst_pkg;

	localparam int OP_W      = 2;
	localparam int PLANE_W   = 7;
	localparam int ROUTE_W   = 11;
	localparam int TIME_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int ENTRY_W   = 5;

	localparam int DEF_CAPACITY = 16;

	// opcodes
	localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP_FIRST = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_LAST  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP       = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [PLANE_W-1:0] plane_id;
		logic [ROUTE_W-1:0] route_id;
		logic [TIME_W-1:0]  sched_time;
	} rec_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic ins;   // insert, table not full
		logic pop;   // release earliest, table not empty
	} cell_ctrl_t;

endpackage

@@ rtl/core/sst_cell.sv @@
// One slot of the sorted chain.
module sst_cell (
	input  logic              clk,
	input  sst_pkg::cell_ctrl_t ctrl,
	input  logic              occ,        // slot holds a record
	input  sst_pkg::rec_t     new_rec,
	input  sst_pkg::rec_t     left_rec,
	input  logic              left_after, // new record lands right of left neighbour
	input  sst_pkg::rec_t     right_rec,
	output sst_pkg::rec_t     rec,
	output logic              after       // new record lands right of this slot
);
	import sst_pkg::*;

	rec_t rec_q;

	assign after = occ && (rec_q.sched_time <= new_rec.sched_time);
	assign rec   = rec_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !after) begin
			// first slot past the key takes the new record, the rest shift right
			if (left_after) begin
				rec_q <= new_rec;
			end else begin
				rec_q <= left_rec;
			end
		end else if (ctrl.pop) begin
			rec_q <= right_rec;
		end
	end

endmodule

@@ rtl/core/sorted_schedule_table.sv @@
// Channel   Ports                                         Beat taken when
// -------   --------------------------------------------  ------------------------
// command   start, busy, opcode, plane_id, route_id,      start high, busy low
//           sched_time
// result    done, status, out_plane_id, out_route_id,     done high (one cycle)
//           out_sched_time, entry_count
//
// Every command is finished in the cycle it is taken; its result beat shows on
// done in the cycle after. A command may follow in every cycle, so busy stays low.
// The limit is one 32-bit compare per cell plus the shift select.
// arst_n clears the record count and the result strobe; the slots themselves
// are not cleared, as only slots below the count are ever read.
// The receiver cannot stall: each result beat lasts exactly one cycle.
`include "sorted_schedule_table_defines.svh"

module sorted_schedule_table #(
	parameter int CAPACITY = sst_pkg::DEF_CAPACITY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [sst_pkg::OP_W-1:0]     opcode,
	input  logic [sst_pkg::PLANE_W-1:0]  plane_id,
	input  logic [sst_pkg::ROUTE_W-1:0]  route_id,
	input  logic [sst_pkg::TIME_W-1:0]   sched_time,
	output logic                         done,
	output logic [sst_pkg::STATUS_W-1:0] status,
	output logic [sst_pkg::PLANE_W-1:0]  out_plane_id,
	output logic [sst_pkg::ROUTE_W-1:0]  out_route_id,
	output logic [sst_pkg::TIME_W-1:0]   out_sched_time,
	output logic [sst_pkg::ENTRY_W-1:0]  entry_count
);
	import sst_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);  // count, 0..CAPACITY
	localparam int IW = $clog2(CAPACITY);      // slot index

	logic            accept;
	logic            full;
	logic            empty;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [IW-1:0]   last_idx;
	cell_ctrl_t      ctrl;
	rec_t            new_rec;
	rec_t            res_rec;
	logic [STATUS_W-1:0] res_status;

	rec_t            cell_rec   [CAPACITY];
	rec_t            lft_rec    [CAPACITY];
	rec_t            rgt_rec    [CAPACITY];
	logic            cell_after [CAPACITY];
	logic            lft_after  [CAPACITY];
	logic            cell_occ   [CAPACITY];

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	rec_t                out_rec_q;
	logic [ENTRY_W-1:0]  entry_q;

	// Every command completes in the cycle it is taken, so never hold the sender off.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign last_idx = IW'(count_q - CW'(1));

	assign new_rec.plane_id   = plane_id;
	assign new_rec.route_id   = route_id;
	assign new_rec.sched_time = sched_time;

	assign ctrl.ins = accept && (opcode == OP_INSERT) && !full;
	assign ctrl.pop = accept && (opcode == OP_POP_FIRST) && !empty;

	// Chain of slots: slot 0 holds the earliest time. Slots below the count
	// are occupied; neighbours are wired so that an insert shifts right and a
	// release of the earliest shifts left, all slots at once.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign lft_rec[i]   = new_rec;
			assign lft_after[i] = 1'b1;
		end else begin : g_body
			assign lft_rec[i]   = cell_rec[i-1];
			assign lft_after[i] = cell_after[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rgt_rec[i] = cell_rec[i];
		end else begin : g_mid
			assign rgt_rec[i] = cell_rec[i+1];
		end

		sst_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occ        (cell_occ[i]),
			.new_rec    (new_rec),
			.left_rec   (lft_rec[i]),
			.left_after (lft_after[i]),
			.right_rec  (rgt_rec[i]),
			.rec        (cell_rec[i]),
			.after      (cell_after[i])
		);
	end

	// Decode the command into its result and the next count.
	always_comb begin
		res_status = ST_OK;
		res_rec    = '0;
		count_d    = count_q;
		case (opcode)
			OP_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			OP_POP_FIRST: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_rec = cell_rec[0];
					count_d = count_q - CW'(1);
				end
			end
			OP_POP_LAST: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_rec = cell_rec[last_idx];
					count_d = count_q - CW'(1);
				end
			end
			OP_NOP: begin
				res_status = ST_OK;
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// Count and result strobe: control state, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// Result payload: hold until the next command.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= res_status;
			out_rec_q <= res_rec;
			entry_q   <= ENTRY_W'(count_d);
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign out_plane_id   = out_rec_q.plane_id;
	assign out_route_id   = out_rec_q.route_id;
	assign out_sched_time = out_rec_q.sched_time;
	assign entry_count    = entry_q;

	`SST_ASSERT_NEXT(a_beat_follows, accept, done, "result beat missing after command")
	`SST_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count beyond capacity")
	`SST_ASSERT_SAME(a_full_stays, done && (status == ST_FULL), full, "full status on non-full table")
	`SST_ASSERT_SAME(a_empty_stays, done && (status == ST_EMPTY), empty, "empty status on held records")

endmodule
